// ===== rtl/hcbp_pkg.sv =====
// hcbp_pkg: shared types and constants for the huffman code bit packer
// used by huffman_code_bit_packer; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

  // longest code the packer accepts, and the width of the code field
  localparam int MaxCodeLen = 32;
  localparam int CodeW      = 32;
  localparam int LenCap     = (MaxCodeLen < CodeW) ? MaxCodeLen : CodeW;
  localparam int LenW       = 6;

  // code table geometry: code in the low bits, length above it
  localparam int TableDepth = 256;
  localparam int SymW       = 8;
  localparam int EntryW     = CodeW + LenW;

  // bit accumulator: one partial byte plus the longest code
  localparam int AccW       = LenCap + 8;
  localparam int TotW       = $clog2(AccW + 1);

  // stream widths
  localparam int InDataW    = 48;
  localparam int InUserW    = 2;
  localparam int OutDataW   = 8;
  localparam int OutUserW   = 5;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/huffman_code_bit_packer.sv =====
// huffman_code_bit_packer: code table lookup and lsb-first bit packing
// depends on hcbp_pkg and hcbp_ram
//
//   channel  dir  payload                                          marker
//   s_*      in   tdata: symbol, code_bits, code_length; tuser: kind  -
//   m_*      out  tdata: packed_byte; tuser: has_byte,             tlast
//                 final_valid_bits, chunk_end
//
// a load writes the code table ram
// a data item does a ram read, then a merge, then emits each completed byte
// a flush needs the output register free
// the single table read port and the one-byte output register set the rate
// reset clears the packer state and the output valid; the output payload and the table are not cleared
// a stall on m_tready holds the output register and the input side waits
`timescale 1ns / 1ps
`default_nettype none

module huffman_code_bit_packer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [7:0] symbol, [39:8] code_bits, [45:40] code_length, [47:46] zero
  input  wire logic [hcbp_pkg::InDataW-1:0]  s_tdata,
  // [1:0] kind
  input  wire logic [hcbp_pkg::InUserW-1:0]  s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [7:0] packed_byte
  output logic      [hcbp_pkg::OutDataW-1:0] m_tdata,
  // [0] has_byte, [3:1] final_valid_bits, [4] chunk_end
  output logic      [hcbp_pkg::OutUserW-1:0] m_tuser,
  output logic                               m_tlast
);

  import hcbp_pkg::*;

  state_t              state, state_next;
  logic [AccW-1:0]     acc, acc_next;
  logic [TotW-1:0]     total, total_next;

  logic                s_acc;
  kind_t               in_kind;
  logic [SymW-1:0]     in_symbol;
  logic [CodeW-1:0]    in_code;
  logic [LenW-1:0]     in_len;
  logic [LenW-1:0]     load_len;

  logic [EntryW-1:0]   ram_rdata;
  logic [CodeW-1:0]    ram_code;
  logic [LenW-1:0]     ram_len;
  logic [LenW-1:0]     eff_len;
  logic [CodeW-1:0]    code_masked;
  logic [AccW-1:0]     merged;
  logic [TotW-1:0]     merged_total;

  logic                out_free;
  logic                out_load;
  logic [7:0]          out_byte_next;
  logic                out_has_next;
  logic [2:0]          out_fvb_next;
  logic                out_end_next;
  logic                out_last_next;
  logic [7:0]          out_byte;
  logic                out_has;
  logic [2:0]          out_fvb;
  logic                out_end;

  // input unpacking
  assign in_kind   = kind_t'(s_tuser);
  assign in_symbol = s_tdata[SymW-1:0];
  assign in_code   = s_tdata[SymW +: CodeW];
  assign in_len    = s_tdata[SymW+CodeW +: LenW];
  assign load_len  = (in_len > LenW'(LenCap)) ? LenW'(LenCap) : in_len;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign s_acc     = s_tvalid && s_tready;

  // code table: written by load transactions, read on every accept
  hcbp_ram #(
    .WIDTH (EntryW),
    .DEPTH (TableDepth)
  ) u_table (
    .clk   (clk),
    .we    (s_acc && (in_kind == KIND_LOAD)),
    .waddr (in_symbol),
    .wdata ({load_len, in_code}),
    .raddr (in_symbol),
    .rdata (ram_rdata)
  );

  // merge the looked-up code above the pending bits
  assign ram_code     = ram_rdata[CodeW-1:0];
  assign ram_len      = ram_rdata[CodeW +: LenW];
  assign eff_len      = (ram_len > LenW'(LenCap)) ? LenW'(LenCap) : ram_len;
  assign code_masked  = ram_code & ~({CodeW{1'b1}} << eff_len);
  assign merged       = acc | (AccW'(code_masked) << total[2:0]);
  assign merged_total = TotW'(total[2:0]) + TotW'(eff_len);

  // state register and packer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      acc   <= '0;
      total <= '0;
    end else begin
      state <= state_next;
      acc   <= acc_next;
      total <= total_next;
    end
  end

  // next state, packer update and output register load
  always_comb begin
    state_next    = state;
    acc_next      = acc;
    total_next    = total;
    out_load      = 1'b0;
    out_byte_next = acc[7:0];
    out_has_next  = 1'b1;
    out_fvb_next  = 3'd0;
    out_end_next  = 1'b0;
    out_last_next = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          case (in_kind)
            KIND_DATA: begin
              state_next = ST_LOOKUP;
            end
            KIND_FLUSH: begin
              out_load      = 1'b1;
              out_has_next  = (total != '0);
              out_fvb_next  = total[2:0];
              out_end_next  = 1'b1;
              out_last_next = 1'b1;
              acc_next      = '0;
              total_next    = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        acc_next   = merged;
        total_next = merged_total;
        state_next = (merged_total >= TotW'(8)) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_last_next = (total < TotW'(16));
          acc_next      = acc >> 8;
          total_next    = total - TotW'(8);
          if (total < TotW'(16)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= out_byte_next;
      out_has  <= out_has_next;
      out_fvb  <= out_fvb_next;
      out_end  <= out_end_next;
      m_tlast  <= out_last_next;
    end
  end

  assign m_tdata = out_byte;
  assign m_tuser = {out_end, out_fvb, out_has};

  // checks on the packer control
  a_emit_has_byte: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (total >= TotW'(8)))
    else $error("emit state entered with less than a byte collected");

  a_idle_partial: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (total < TotW'(8)))
    else $error("packer idle with a complete byte still held");

  a_flush_result: assert property (@(posedge clk) disable iff (rst)
    (s_acc && (in_kind == KIND_FLUSH)) |=> (m_tvalid && out_end && m_tlast && (total == '0)))
    else $error("flush transaction did not close the chunk");

  a_data_lookup: assert property (@(posedge clk) disable iff (rst)
    (s_acc && (in_kind == KIND_DATA)) |=> (state == ST_LOOKUP) && !s_tready)
    else $error("data transaction did not start a table lookup");

endmodule

`default_nettype wire

// ===== rtl/hcbp_ram.sv =====
// hcbp_ram: generic single write port, single read port ram
// registered read data; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sim/huffman_code_bit_packer_tb.sv =====
// huffman_code_bit_packer_tb: self-checking testbench for the huffman code bit packer
// predicts packed bytes from its own code table copy; depends on hcbp_pkg and the rtl
`timescale 1ns / 1ps

module huffman_code_bit_packer_tb;
  import hcbp_pkg::*;

  // kind value that the block must ignore
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // one output transaction as the block should present it
  typedef struct packed {
    logic [7:0] byte_val;
    logic       has_byte;
    logic [2:0] valid_bits;
    logic       chunk_end;
    logic       is_last;
  } packed_out_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [InUserW-1:0]  s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [OutUserW-1:0] m_tuser;
  logic                m_tlast;

  // predicted packer state
  logic [31:0]   code_tab [TableDepth];
  logic [5:0]    len_tab [TableDepth];
  logic [7:0]    pend_byte = 8'd0;
  logic [2:0]    pend_bits = 3'd0;
  packed_out_t   packed_q [$];

  // stimulus bookkeeping
  logic          sym_loaded [TableDepth];
  logic [7:0]    loaded_syms [$];
  int            burst_left = 0;
  int            hold_off_cycles = 0;
  int            fail_count = 0;

  huffman_code_bit_packer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // update the predicted packer for one accepted input transaction
  function automatic void pack_code_bits(input logic [1:0] kind, input logic [7:0] sym,
                                         input logic [31:0] code, input logic [5:0] len);
    logic [63:0] acc;
    int          total;
    int          width;
    packed_out_t res;
    case (kind)
      KIND_LOAD: begin
        code_tab[sym] = code;
        len_tab[sym]  = (int'(len) > LenCap) ? 6'(LenCap) : len;
      end
      KIND_DATA: begin
        width = len_tab[sym];
        acc   = {56'd0, pend_byte} |
                ((64'(code_tab[sym]) & ((64'd1 << width) - 64'd1)) << pend_bits);
        total = int'(pend_bits) + width;
        // every full byte goes out, the last one of the item marked
        while (total >= 8) begin
          total          -= 8;
          res.byte_val   = acc[7:0];
          res.has_byte   = 1'b1;
          res.valid_bits = 3'd0;
          res.chunk_end  = 1'b0;
          res.is_last    = (total < 8);
          packed_q = {packed_q, res};
          acc = acc >> 8;
        end
        pend_bits = total[2:0];
        pend_byte = acc[7:0];
      end
      KIND_FLUSH: begin
        res.byte_val   = pend_byte;
        res.has_byte   = (pend_bits != 3'd0);
        res.valid_bits = pend_bits;
        res.chunk_end  = 1'b1;
        res.is_last    = 1'b1;
        packed_q = {packed_q, res};
        pend_byte = 8'd0;
        pend_bits = 3'd0;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    packed_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (packed_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual byte %0h user %0h last %0b",
                 $time, m_tdata, m_tuser, m_tlast);
        fail_count++;
      end else begin
        want = packed_q.pop_front();
        check_field("packed_byte", want.byte_val, m_tdata);
        check_field("has_byte", 8'(want.has_byte), 8'(m_tuser[0]));
        check_field("final_valid_bits", 8'(want.valid_bits), 8'(m_tuser[3:1]));
        check_field("chunk_end", 8'(want.chunk_end), 8'(m_tuser[4]));
        check_field("last_of_run", 8'(want.is_last), 8'(m_tlast));
      end
    end
  end

  // output ready: all-ready, pattern and coin-flip stretches, plus requested hold-offs
  initial begin : out_ready_gen
    int          mode;
    int          span;
    int          hold;
    logic [15:0] pat;
    logic [3:0]  k;
    mode = 0;
    span = 0;
    pat  = 16'hFFFF;
    k    = 4'd0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        hold = hold_off_cycles;
        hold_off_cycles = 0;
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(20, 80);
        pat  = 16'($urandom) | 16'h0001;
      end
      span--;
      k++;
      case (mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= pat[k];
        default: m_tready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // offer one input transaction, wait for it to be taken, then maybe idle
  task automatic send_item(input logic [1:0] kind, input logic [7:0] sym,
                           input logic [31:0] code, input logic [5:0] len);
    int gap;
    s_tdata  <= {2'b00, len, code, sym};
    s_tuser  <= kind;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pack_code_bits(kind, sym, code, len);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic load_code(input logic [7:0] sym, input logic [31:0] code,
                           input logic [5:0] len);
    if (!sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms = {loaded_syms, sym};
    end
    send_item(KIND_LOAD, sym, code, len);
  endtask

  function automatic logic [7:0] pick_loaded_sym();
    return loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
  endfunction

  // hold input idle until every predicted byte has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (packed_q.size() != 0);
  endtask

  // extremes, saturation, masking, zero-length codes, flush cases, ignored kind
  task automatic test_directed_cases();
    load_code(8'h00, 32'hFFFF_FFFF, 6'd32);
    load_code(8'hFF, 32'hFFFF_FFFE, 6'd1);
    load_code(8'h5A, 32'hDEAD_BEEF, 6'd0);
    load_code(8'hA5, 32'h1234_5678, 6'd63);
    load_code(8'h3C, 32'h8000_0001, 6'd33);
    load_code(8'h11, 32'h0000_0005, 6'd3);
    load_code(8'h80, 32'h0000_0000, 6'd8);
    send_item(KIND_DATA, 8'h00, 32'd0, 6'd0);
    send_item(KIND_DATA, 8'hFF, 32'd0, 6'd0);
    send_item(KIND_DATA, 8'h11, 32'd0, 6'd0);
    send_item(KIND_DATA, 8'h5A, 32'd0, 6'd0);
    send_item(KIND_DATA, 8'hA5, 32'd0, 6'd0);
    send_item(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    send_item(KIND_DATA, 8'h3C, 32'd0, 6'd0);
    send_item(KIND_FLUSH, 8'h00, 32'd0, 6'd0);
    send_item(KIND_FLUSH, 8'h00, 32'd0, 6'd0);
    send_item(KIND_DATA, 8'h80, 32'd0, 6'd0);
    send_item(KIND_FLUSH, 8'h00, 32'd0, 6'd0);
    send_item(KIND_DATA, 8'h11, 32'd0, 6'd0);
    send_item(KIND_DATA, 8'h11, 32'd0, 6'd0);
    send_item(KIND_DATA, 8'hFF, 32'd0, 6'd0);
    send_item(KIND_FLUSH, 8'h00, 32'd0, 6'd0);
    send_item(KIND_DATA, 8'h00, 32'd0, 6'd0);
    send_item(KIND_DATA, 8'h80, 32'd0, 6'd0);
    send_item(KIND_UNUSED, 8'h00, 32'd0, 6'd0);
    send_item(KIND_FLUSH, 8'h00, 32'd0, 6'd0);
  endtask

  // mostly data on loaded symbols, with reloads, chunk ends and ignored items
  task automatic test_random_stream(input int n_items);
    int         r;
    int         pick;
    logic [5:0] len;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 18) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)      len = 6'd0;
        else if (pick == 1) len = 6'($urandom_range(33, 63));
        else if (pick < 5)  len = 6'($urandom_range(13, 32));
        else                len = 6'($urandom_range(1, 12));
        load_code(8'($urandom), $urandom, len);
      end else if (r < 90) begin
        send_item(KIND_DATA, pick_loaded_sym(), $urandom, 6'($urandom));
      end else if (r < 98) begin
        send_item(KIND_FLUSH, 8'($urandom), $urandom, 6'($urandom));
      end else begin
        send_item(KIND_UNUSED, 8'($urandom), $urandom, 6'($urandom));
      end
    end
  endtask

  // long output hold-off while long codes keep arriving, so the input stalls
  task automatic test_output_hold_off();
    load_code(8'hC3, $urandom, 6'd32);
    hold_off_cycles = 300;
    for (int i = 0; i < 18; i++)
      send_item(KIND_DATA, 8'hC3, 32'd0, 6'd0);
    send_item(KIND_FLUSH, 8'h00, 32'd0, 6'd0);
  endtask

  // input pauses mid-chunk until all predicted bytes are out, then resumes
  task automatic test_pause_until_drained();
    for (int i = 0; i < 6; i++)
      send_item(KIND_DATA, pick_loaded_sym(), 32'd0, 6'd0);
    wait_drained();
    for (int i = 0; i < 6; i++)
      send_item(KIND_DATA, pick_loaded_sym(), 32'd0, 6'd0);
    send_item(KIND_FLUSH, 8'h00, 32'd0, 6'd0);
  endtask

  initial begin
    for (int i = 0; i < TableDepth; i++)
      sym_loaded[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_stream(172);
    test_output_hold_off();
    test_pause_until_drained();
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
